[hw/rtl/perspective_to_planar_depth_macros.svh]
// assertion macros for the perspective-to-planar depth block
// used by the top level; expects clk and rst_n in scope
`ifndef PERSPECTIVE_TO_PLANAR_DEPTH_MACROS_SVH
`define PERSPECTIVE_TO_PLANAR_DEPTH_MACROS_SVH

// implication checked at every clock edge outside reset
`define PPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define PPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ppd_pkg.sv]
// shared constants for the perspective-to-planar depth block
// no dependencies
`default_nettype none

package ppd_pkg;

    localparam int FOCAL_W    = 12;   // focal length register
    localparam int DIM_W      = 13;   // image width / height registers
    localparam int COORD_W    = 12;   // column / row fields
    localparam int OFS_W      = 15;   // signed doubled offset from center
    localparam int ABS_W      = 14;   // magnitude of doubled offset
    localparam int F2_W       = 13;   // doubled focal length
    localparam int DEN_W      = 28;   // (2f)^2 + dx2^2 + dy2^2
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 12'd128;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd256;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_LENGTH = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

[hw/rtl/perspective_to_planar_depth.sv]
// throughput: one item per cycle while out_ready holds; three geometry stages then one stage per result bit
// each stage holds while it is full and its successor cannot load, so bubbles close up under a stall
// reset: asynchronous active low; clears stage valid bits and loads the register
// defaults focal_length 128, image_width 256, image_height 144
`default_nettype none

`include "perspective_to_planar_depth_macros.svh"

module perspective_to_planar_depth
    import ppd_pkg::*;
#(
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [COORD_W-1:0]      column,
    input  wire logic [COORD_W-1:0]      row,
    input  wire logic [DEPTH_BITS-1:0]   ray_depth,
    // result items
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [DEPTH_BITS-1:0]        flat_depth
);

    localparam int NS    = DEPTH_BITS + 3;          // total stages
    localparam int REM_W = 2 * (DEPTH_BITS + F2_W);
    localparam int QD_W  = DEPTH_BITS + DEN_W;

    // configuration registers
    logic [FOCAL_W-1:0] focal_length_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_length_reg <= FOCAL_RESET;
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FOCAL_LENGTH: focal_length_reg <= cfg_data[FOCAL_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                default:          ; // unused index, write dropped
            endcase
        end
    end

    // stage valid bits and per-stage load enables
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    // a stage loads when it is empty or its content moves on this cycle
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (!en[i])
                valid_next[i] = valid_reg[i];
            else if (i == 0)
                valid_next[i] = in_valid;
            else
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];

    // datapath: index 0 is the front end output, index k the k-th root bit stage
    logic [REM_W-1:0]      rem_s [DEPTH_BITS+1];
    logic [QD_W-1:0]       qd_s  [DEPTH_BITS+1];
    logic [DEPTH_BITS-1:0] q_s   [DEPTH_BITS+1];
    logic [DEN_W-1:0]      den_s [DEPTH_BITS+1];
    logic                  fz_s  [DEPTH_BITS+1];

    ppd_front #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk          (clk),
        .en           (en[2:0]),
        .column       (column),
        .row          (row),
        .ray_depth    (ray_depth),
        .focal_length (focal_length_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .den          (den_s[0]),
        .lim          (rem_s[0]),
        .f_zero       (fz_s[0])
    );

    // search starts with q = 0, q*den = 0 and the whole squared numerator left
    assign qd_s[0] = '0;
    assign q_s[0]  = '0;

    // one stage per result bit, most significant first
    for (genvar k = 1; k <= DEPTH_BITS; k++)
    begin : g_root
        ppd_root_step #(
            .DEPTH_BITS (DEPTH_BITS),
            .BIT        (DEPTH_BITS - k)
        ) u_step (
            .clk     (clk),
            .en      (en[k+2]),
            .rem_in  (rem_s[k-1]),
            .qd_in   (qd_s[k-1]),
            .q_in    (q_s[k-1]),
            .den_in  (den_s[k-1]),
            .fz_in   (fz_s[k-1]),
            .rem_out (rem_s[k]),
            .qd_out  (qd_s[k]),
            .q_out   (q_s[k]),
            .den_out (den_s[k]),
            .fz_out  (fz_s[k])
        );
    end

    // zero focal length never sets a bit, so it reads out as zero
    assign flat_depth = q_s[DEPTH_BITS];

    // empty output stage means every stage can load
    `PPD_ASSERT_IMPL(a_empty_ready, !valid_reg[NS-1], in_ready, "pipe stalled while output empty")
    // an accepted item lands in the first stage
    `PPD_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, valid_reg[0], "accepted item lost")
    // a held output keeps its valid bit
    `PPD_ASSERT_NEXT(a_hold_out, valid_reg[NS-1] && !out_ready, valid_reg[NS-1], "result dropped")

endmodule

`default_nettype wire

[hw/rtl/ppd_front.sv]
// geometry front end: offsets, squares, denominator and squared numerator
// three register stages; uses ppd_pkg
`default_nettype none

module ppd_front
    import ppd_pkg::*;
#(
    parameter int DEPTH_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic [2:0]                  en,
    input  wire logic [COORD_W-1:0]          column,
    input  wire logic [COORD_W-1:0]          row,
    input  wire logic [DEPTH_BITS-1:0]       ray_depth,
    input  wire logic [FOCAL_W-1:0]          focal_length,
    input  wire logic [DIM_W-1:0]            image_width,
    input  wire logic [DIM_W-1:0]            image_height,
    output logic [DEN_W-1:0]                 den,
    output logic [2*(DEPTH_BITS+F2_W)-1:0]   lim,
    output logic                             f_zero
);

    localparam int NUM_W = DEPTH_BITS + F2_W;
    localparam int LIM_W = 2 * NUM_W;

    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    logic [OFS_W-1:0]        dx_mag;
    logic [OFS_W-1:0]        dy_mag;

    // stage 0
    logic [ABS_W-1:0]      dxa_reg, dya_reg;
    logic [F2_W-1:0]       f2_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic                  fz0_reg;
    // stage 1
    logic [DEN_W-1:0]      sqx_reg, sqy_reg, ff_reg;
    logic [NUM_W-1:0]      num_reg;
    logic                  fz1_reg;
    // stage 2
    logic [DEN_W-1:0]      den_reg;
    logic [LIM_W-1:0]      lim_reg;
    logic                  fz2_reg;

    always_comb
    begin
        dx = $signed({2'b00, column, 1'b0}) - $signed({2'b00, image_width}) + 15'sd2;
        dy = $signed({2'b00, row, 1'b0}) - $signed({2'b00, image_height}) + 15'sd2;
        dx_mag = dx[OFS_W-1] ? (~dx + 15'd1) : dx;
        dy_mag = dy[OFS_W-1] ? (~dy + 15'd1) : dy;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dxa_reg   <= dx_mag[ABS_W-1:0];
            dya_reg   <= dy_mag[ABS_W-1:0];
            f2_reg    <= {focal_length, 1'b0};
            depth_reg <= ray_depth;
            fz0_reg   <= (focal_length == '0);
        end
        if (en[1])
        begin
            sqx_reg <= DEN_W'(dxa_reg) * DEN_W'(dxa_reg);
            sqy_reg <= DEN_W'(dya_reg) * DEN_W'(dya_reg);
            ff_reg  <= DEN_W'(f2_reg) * DEN_W'(f2_reg);
            num_reg <= NUM_W'(depth_reg) * NUM_W'(f2_reg);
            fz1_reg <= fz0_reg;
        end
        if (en[2])
        begin
            den_reg <= sqx_reg + sqy_reg + ff_reg;
            lim_reg <= LIM_W'(num_reg) * LIM_W'(num_reg);
            fz2_reg <= fz1_reg;
        end
    end

    assign den    = den_reg;
    assign lim    = lim_reg;
    assign f_zero = fz2_reg;

endmodule

`default_nettype wire

[hw/rtl/ppd_root_step.sv]
// one bit of the restoring root search: tests q | 2^BIT against the remainder
// single register stage, no multiplier; uses ppd_pkg
`default_nettype none

module ppd_root_step
    import ppd_pkg::*;
#(
    parameter int DEPTH_BITS = 16,
    parameter int BIT        = 15
) (
    input  wire logic                               clk,
    input  wire logic                               en,
    input  wire logic [2*(DEPTH_BITS+F2_W)-1:0]     rem_in,
    input  wire logic [DEPTH_BITS+DEN_W-1:0]        qd_in,
    input  wire logic [DEPTH_BITS-1:0]              q_in,
    input  wire logic [DEN_W-1:0]                   den_in,
    input  wire logic                               fz_in,
    output logic [2*(DEPTH_BITS+F2_W)-1:0]          rem_out,
    output logic [DEPTH_BITS+DEN_W-1:0]             qd_out,
    output logic [DEPTH_BITS-1:0]                   q_out,
    output logic [DEN_W-1:0]                        den_out,
    output logic                                    fz_out
);

    localparam int REM_W = 2 * (DEPTH_BITS + F2_W);
    localparam int QD_W  = DEPTH_BITS + DEN_W;
    localparam int T_W   = 2 * DEPTH_BITS + DEN_W + 1;

    // growth of q^2*den when bit is set: (2q*2^b + 2^2b)*den
    logic [T_W-1:0] growth;
    logic           fit;

    logic [REM_W-1:0]      rem_reg;
    logic [QD_W-1:0]       qd_reg;
    logic [DEPTH_BITS-1:0] q_reg;
    logic [DEN_W-1:0]      den_reg;
    logic                  fz_reg;

    always_comb
    begin
        growth = (T_W'(den_in) << (2 * BIT)) + (T_W'(qd_in) << (BIT + 1));
        fit    = !fz_in && (growth <= T_W'(rem_in));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= fit ? (rem_in - REM_W'(growth)) : rem_in;
            qd_reg  <= fit ? (qd_in + (QD_W'(den_in) << BIT)) : qd_in;
            q_reg   <= fit ? (q_in | (DEPTH_BITS'(1) << BIT)) : q_in;
            den_reg <= den_in;
            fz_reg  <= fz_in;
        end
    end

    assign rem_out = rem_reg;
    assign qd_out  = qd_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;
    assign fz_out  = fz_reg;

endmodule

`default_nettype wire

[verif/perspective_to_planar_depth_test.sv]
// testbench for the perspective-to-planar depth block: directed and random pixels,
// scoreboard class predicts each planar depth; depends on ppd_pkg and the rtl top
`default_nettype none

module perspective_to_planar_depth_test
    import ppd_pkg::*;
();

    localparam int DBITS = 16;

    // depth predictor and queue of expected planar depths
    class depth_scoreboard;
        logic [FOCAL_W-1:0] focal;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DBITS-1:0]   pending[$];
        int                 errors;

        function new();
            focal  = FOCAL_RESET;
            width  = WIDTH_RESET;
            height = HEIGHT_RESET;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FOCAL_LENGTH: focal  = val[FOCAL_W-1:0];
                REG_IMAGE_WIDTH:  width  = val;
                REG_IMAGE_HEIGHT: height = val;
                default: ;
            endcase
        endfunction

        function logic [DBITS-1:0] planar(logic [COORD_W-1:0] col,
                                          logic [COORD_W-1:0] rw,
                                          logic [DBITS-1:0] depth);
            longint dx2, dy2, f2, den, num, lim, q, c;
            dx2 = 2 * longint'(col) - longint'(width) + 2;
            dy2 = 2 * longint'(rw) - longint'(height) + 2;
            f2  = 2 * longint'(focal);
            den = f2 * f2 + dx2 * dx2 + dy2 * dy2;
            num = longint'(depth) * f2;
            lim = num * num;
            q   = 0;
            if (focal == 0 || depth == 0)
                return '0;
            for (int b = DBITS - 1; b >= 0; b--)
            begin
                c = q | (longint'(1) << b);
                // c*c*den fits: c < 2^16, den < 2^28
                if (c <= depth && c * c * den <= lim)
                    q = c;
            end
            return q[DBITS-1:0];
        endfunction

        function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] rw,
                                 logic [DBITS-1:0] depth);
            pending.push_back(planar(col, rw, depth));
        endfunction

        function bit check_depth(logic [DBITS-1:0] got, output logic [DBITS-1:0] want);
            if (pending.size() == 0)
            begin
                want = 'x;
                return 0;
            end
            want = pending.pop_front();
            return got === want;
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 0;
    logic                  in_ready;
    logic [COORD_W-1:0]    column = '0;
    logic [COORD_W-1:0]    row = '0;
    logic [DBITS-1:0]      ray_depth = '0;
    logic                  out_valid;
    logic                  out_ready = 0;
    logic [DBITS-1:0]      flat_depth;

    depth_scoreboard sb = new();
    int  mismatches = 0;
    bit  calm = 0;      // no idling in the last part of the run

    perspective_to_planar_depth #(.DEPTH_BITS(DBITS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .column(column), .row(row), .ray_depth(ray_depth),
        .out_valid(out_valid), .out_ready(out_ready), .flat_depth(flat_depth)
    );

    always #5 clk = ~clk;

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // write one register; block is idle whenever this is called
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic write_geometry(int f, int w, int h);
        write_reg(REG_FOCAL_LENGTH, CFG_DATA_W'(f));
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    endtask

    // present one pixel item and hold it until accepted, with an optional gap first
    task automatic send_pixel(int col, int rw, int depth);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1;
        column    <= COORD_W'(col);
        row       <= COORD_W'(rw);
        ray_depth <= DBITS'(depth);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(COORD_W'(col), COORD_W'(rw), DBITS'(depth));
    endtask

    // wait for all expected items, then past the pipeline latency
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DBITS + 8) @(posedge clk);
    endtask

    // random pixel: mostly inside the image, sometimes anywhere
    task automatic random_pixel();
        int col, rw, depth;
        if ($urandom_range(0, 4) == 0)
        begin
            col = $urandom_range(0, 4095);
            rw  = $urandom_range(0, 4095);
        end
        else
        begin
            col = (sb.width  > 1) ? $urandom_range(0, (sb.width  - 1) % 4096) : 0;
            rw  = (sb.height > 1) ? $urandom_range(0, (sb.height - 1) % 4096) : 0;
        end
        case ($urandom_range(0, 5))
            0: depth = 16'hFFFF;
            1: depth = $urandom_range(0, 15);
            default: depth = $urandom_range(0, 65535);
        endcase
        send_pixel(col, rw, depth);
    endtask

    // receiver: random stall bursts, checks every accepted result
    always @(posedge clk)
    begin
        logic [DBITS-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (!sb.check_depth(flat_depth, want))
                report($sformatf("flat_depth got %0d expected %0d", flat_depth, want));
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall = $urandom_range(1, 14);
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset geometry, extremes of each field
        send_pixel(0, 0, 0);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(127, 71, 16'hFFFF);       // center pixel keeps full depth
        send_pixel(255, 143, 16'h0100);
        send_pixel(4095, 4095, 16'hFFFF);    // outside the image
        send_pixel(4095, 0, 1);
        send_pixel(0, 4095, 16'h8000);
        send_pixel(12'hAAA, 12'h555, 16'hAAAA);
        send_pixel(12'h555, 12'hAAA, 16'h5555);
        drain();
        // zero focal length gives zero depth
        write_reg(REG_FOCAL_LENGTH, '0);
        send_pixel(10, 10, 16'hFFFF);
        send_pixel(4095, 4095, 16'h1234);
        drain();
        // register extremes, including width and height beyond their range
        write_geometry(4095, 4096, 4096);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(2047, 2047, 16'hFFFF);
        send_pixel(4095, 4095, 16'hFFFF);
        drain();
        write_geometry(1, 2, 2);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(1, 1, 16'hFFFF);
        send_pixel(4095, 4095, 16'hFFFF);
        drain();
        write_geometry(1, 8191, 0);
        send_pixel(0, 0, 16'hFFFF);
        send_pixel(4095, 4095, 16'hFFFF);
        drain();
        // unused register index is ignored by the block
        cfg_we    <= 1;
        cfg_index <= 2'd3;
        cfg_data  <= 13'h1FFF;
        @(posedge clk);
        cfg_we <= 0;
        send_pixel(5, 5, 16'h7777);
        drain();

        // random phases over several geometries
        for (int ph = 0; ph < 11; ph++)
        begin
            drain();
            case (ph % 4)
                0: write_geometry($urandom_range(1, 4095), $urandom_range(2, 4096),
                                  $urandom_range(2, 4096));
                1: write_geometry($urandom_range(1, 64), $urandom_range(2, 64),
                                  $urandom_range(2, 64));
                2: write_geometry(4095, $urandom_range(2, 8191), $urandom_range(0, 8191));
                default: write_geometry($urandom_range(0, 4095), 640, 480);
            endcase
            if (ph == 10)
                calm = 1;
            repeat (50) random_pixel();
        end
        drain();

        if (mismatches == 0)
            $display("perspective_to_planar_depth_test: clean");
        else
            $display("perspective_to_planar_depth_test: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("perspective_to_planar_depth_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
